>>> hw/rtl/ptds_pkg.sv
// Package: shared constants, opcodes and types of the periodic task due scheduler.
`default_nettype none

package ptds_pkg;

  localparam int TASKS     = 6;
  localparam int TIME_W    = 32;
  localparam int PER_W     = 16;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic {
    OP_ALIGN = 1'b0,
    OP_POLL  = 1'b1
  } ptds_op_t;

  typedef logic [TIME_W-1:0] ptds_time_t;
  typedef logic [PER_W-1:0]  ptds_per_t;
  typedef logic [TASKS-1:0]  ptds_mask_t;

  // Per-lane outcome of one item.
  typedef struct packed {
    logic       due;
    ptds_time_t next_time;
  } ptds_lane_res_t;

  // Reset period of each task register.
  function automatic ptds_per_t period_reset(input int idx);
    ptds_per_t p;
    case (idx)
      0:       p = PER_W'(33);
      1:       p = PER_W'(16);
      2:       p = PER_W'(340);
      3:       p = PER_W'(320);
      4:       p = PER_W'(10);
      5:       p = PER_W'(98);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ptds_ifs.sv
// Interfaces: input item channel and result channel, valid/ready.
`default_nettype none

interface ptds_in_if;
  import ptds_pkg::*;
  logic       valid;
  logic       ready;
  ptds_op_t   opcode;
  ptds_time_t now_tick;

  modport source (output valid, output opcode, output now_tick, input ready);
  modport sink   (input valid, input opcode, input now_tick, output ready);
endinterface

interface ptds_out_if;
  import ptds_pkg::*;
  logic       valid;
  logic       ready;
  ptds_mask_t due_mask;

  modport source (output valid, output due_mask, input ready);
  modport sink   (input valid, input due_mask, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptds_lane.sv
// One task lane: elapsed time, due test and next timestamp.
`default_nettype none

module ptds_lane
  import ptds_pkg::*;
(
  input  wire ptds_op_t   opcode,
  input  wire ptds_time_t now_tick,
  input  wire ptds_time_t last_time,
  input  wire ptds_per_t  period,
  output ptds_lane_res_t  res
);

  ptds_time_t              elapsed;
  logic [PER_W:0]          per_x2;
  logic                    due;
  logic                    resync;

  always_comb begin
    elapsed = now_tick - last_time;            // wraps mod 2^TIME_W
    per_x2  = {period, 1'b0};
    due     = elapsed >= TIME_W'(period);
    resync  = {1'b0, elapsed} > (TIME_W + 1)'(per_x2);

    res.due       = 1'b0;
    res.next_time = last_time;
    case (opcode)
      OP_ALIGN: begin
        res.next_time = now_tick;
      end
      OP_POLL: begin
        res.due = due;
        if (due) begin
          res.next_time = resync ? now_tick : last_time + TIME_W'(period);
        end
      end
      default: begin
        res.next_time = last_time;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/periodic_task_due_scheduler_core.sv
// Top level: periodic task due scheduler with six timestamp lanes.
`default_nettype none

// Drift-free periodic scheduler for six tasks. Each item on in_ch is either an
// align beat (opcode 0: every last-fire timestamp is set to now_tick, result
// mask is zero) or a poll beat (opcode 1: each task whose elapsed time, taken
// mod 2^32, reaches its period fires; it advances by one period, or resyncs to
// now when more than twice the period has gone by). Every item yields exactly
// one due_mask beat on out_ch, in order. Throughput is one item per cycle while
// out_ch keeps ready high. Each item passes through the input register, then
// the result register; while the result slot is stalled, the item waits in
// the input register. The rate is set by the six subtract/compare lanes that
// read the timestamp registers and write them back in the same cycle, so the
// next item always sees the updated timestamps. Periods sit in cfg registers
// 0..5 and may be written only while the block is idle; writes to other
// indexes are dropped.

module periodic_task_due_scheduler_core
  import ptds_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  ptds_in_if.sink              in_ch,
  ptds_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire ptds_per_t       cfg_data
);

  // Config and timestamp state.
  ptds_per_t      period_r    [TASKS];
  ptds_time_t     last_fire_r [TASKS];

  // Input stage.
  logic           s1_valid_r;
  ptds_op_t       s1_op_r;
  ptds_time_t     s1_now_r;

  // Result stage.
  logic           out_valid_r;
  ptds_mask_t     out_mask_r;
  ptds_mask_t     out_mask_nxt;

  ptds_lane_res_t lane_res [TASKS];
  logic           s1_move;
  logic           in_take;

  // Stage 1 drains when the result slot is free or being emptied.
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.due_mask = out_mask_r;

  for (genvar t = 0; t < TASKS; t++) begin : g_lane
    ptds_lane u_lane (
      .opcode    (s1_op_r),
      .now_tick  (s1_now_r),
      .last_time (last_fire_r[t]),
      .period    (period_r[t]),
      .res       (lane_res[t])
    );

    always_comb out_mask_nxt[t] = lane_res[t].due;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        period_r[t]    <= period_reset(t);
        last_fire_r[t] <= '0;
      end else begin
        if (cfg_we && (cfg_idx == CFG_IDX_W'(t))) begin
          period_r[t] <= cfg_data;
        end
        if (s1_move) begin
          last_fire_r[t] <= lane_res[t].next_time;
        end
      end
    end
  end

  // Input register: control reset, payload unreset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r  <= in_ch.opcode;
      s1_now_r <= in_ch.now_tick;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_mask_r <= out_mask_nxt;
    end
  end

  // Checks.
  logic all_eq;
  always_comb begin
    all_eq = 1'b1;
    for (int t = 1; t < TASKS; t++) begin
      if (last_fire_r[t] != last_fire_r[0]) all_eq = 1'b0;
    end
  end

  // Align beat: all timestamps land on now, and the mask is empty.
  a_align_sync: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_op_r == OP_ALIGN) |=> all_eq && (last_fire_r[0] == $past(s1_now_r)))
    else $error("align did not set all timestamps to now");

  a_align_mask: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (s1_op_r == OP_ALIGN) |=> out_valid_r && (out_mask_r == '0))
    else $error("align produced a nonzero due mask");

  // A stalled input stage keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_now_r) && $stable(s1_op_r))
    else $error("input stage lost a stalled item");

  // Timestamps change only when an item is consumed.
  a_ts_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(last_fire_r[0]))
    else $error("timestamp changed without an item");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench: checks the periodic task due scheduler beat by beat against a built-in predictor.
`timescale 1ns / 1ps

module testbench;
  import ptds_pkg::*;

  // Reset values of the six period registers.
  localparam ptds_per_t PERIOD_AT_RESET [TASKS] = '{16'd33, 16'd16, 16'd340, 16'd320,
                                                    16'd10, 16'd98};
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 205;  // random beats per phase
  localparam int HOLD_LEN   = 300;  // long receiver stall, in cycles
  localparam int DRAIN_WAIT = 4;    // cycles past the last result before a cfg write

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  ptds_per_t            cfg_data;

  ptds_in_if  in_ch ();
  ptds_out_if out_ch ();

  periodic_task_due_scheduler_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Scheduler state as the testbench sees it: periods and last-fire stamps.
  ptds_per_t  task_period [TASKS];
  ptds_time_t last_fire   [TASKS];

  // Masks still owed by the block, oldest first.
  ptds_mask_t due_q [$];

  // Idle and stall controls, changed per phase by the stimulus.
  bit in_idle_on;
  bit out_idle_on;
  bit hold_req;

  // Run statistics.
  int fail_count;
  int align_beats;
  int poll_beats;
  int masks_checked;
  int fired_bits;
  int long_holds;

  // One row of the directed table: either a beat or a register write.
  typedef struct {
    bit                   is_cfg;
    ptds_op_t             op;
    ptds_time_t           now;
    bit                   typed;   // expected mask given in the row
    ptds_mask_t           mask;
    logic [CFG_IDX_W-1:0] idx;
    ptds_per_t            per;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Advance the scheduler state by one beat and return the tasks that fire.
  // Align: every stamp jumps to now, nothing fires.
  // Poll: elapsed = now - stamp (mod 2^32). Due when elapsed >= period; then
  // resync to now if elapsed > 2*period, else step the stamp by one period.
  // The doubled period is kept at 17 bits so it never wraps.
  function automatic ptds_mask_t fire_tasks(input ptds_op_t op, input ptds_time_t now);
    ptds_mask_t        fired;
    ptds_time_t        gone;
    logic [PER_W:0]    twice;
    fired = '0;
    for (int t = 0; t < TASKS; t++) begin
      if (op == OP_ALIGN) begin
        last_fire[t] = now;
      end else begin
        gone  = now - last_fire[t];
        twice = {task_period[t], 1'b0};
        if (gone >= ptds_time_t'(task_period[t])) begin
          if (gone > ptds_time_t'(twice)) last_fire[t] = now;
          else last_fire[t] = last_fire[t] + ptds_time_t'(task_period[t]);
          fired[t] = 1'b1;
        end
      end
    end
    return fired;
  endfunction

  // Offer one beat after a random gap; predict once it is taken.
  // Valid stays high on return, so the caller either sends again in the
  // same step or lowers it.
  task automatic send_beat(input ptds_op_t op, input ptds_time_t now,
                           input bit typed, input ptds_mask_t typed_mask);
    int         gap;
    ptds_mask_t fired;
    gap = in_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.now_tick <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fired = fire_tasks(op, now);
    due_q.push_back(typed ? typed_mask : fired);
    if (op == OP_ALIGN) align_beats++;
    else poll_beats++;
  endtask

  // Register write, only with the block drained and quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input ptds_per_t val);
    in_ch.valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // indexes past the last period register are dropped by the block
    if (idx < NUM_REGS) task_period[idx] = val;
  endtask

  function automatic dir_row_t beat_row(input ptds_op_t op, input ptds_time_t now,
                                        input bit typed, input ptds_mask_t mask);
    dir_row_t r;
    r = '{is_cfg: 1'b0, op: op, now: now, typed: typed, mask: mask, idx: '0, per: '0};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input ptds_per_t per);
    dir_row_t r;
    r = '{is_cfg: 1'b1, op: OP_ALIGN, now: '0, typed: 1'b0, mask: '0, idx: idx, per: per};
    return r;
  endfunction

  // Result side: random stall per beat, one long hold on request, and the
  // compare against the oldest owed mask.
  initial begin
    int         stall;
    ptds_mask_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long back-pressure: the block fills and stops taking input
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_LEN; k++) @(posedge clk);
        long_holds++;
      end
      stall = out_idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result beat, due_mask %b", $time, out_ch.due_mask);
        fail_count++;
      end else begin
        want = due_q.pop_front();
        masks_checked++;
        fired_bits += $countones(out_ch.due_mask);
        if (out_ch.due_mask !== want) begin
          $display("%0t: due_mask mismatch, expected %b, actual %b",
                   $time, want, out_ch.due_mask);
          fail_count++;
        end
      end
    end
  end

  // Main stimulus: reset, directed table, then random phases with fresh periods.
  initial begin
    int         r;
    int         t;
    int         span;
    ptds_time_t cur;
    ptds_per_t  p;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_POLL;
    in_ch.now_tick <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    hold_req       = 1'b0;
    for (int i = 0; i < TASKS; i++) begin
      task_period[i] = PERIOD_AT_RESET[i];
      last_fire[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset periods, stamps at zero. Fixed masks where obvious.
    dir_rows.push_back(beat_row(OP_POLL,  32'd0,  1'b1, 6'b000000)); // nothing elapsed
    dir_rows.push_back(beat_row(OP_POLL,  32'd9,  1'b1, 6'b000000)); // one short of fan
    dir_rows.push_back(beat_row(OP_POLL,  32'd10, 1'b1, 6'b010000)); // fan on the dot
    dir_rows.push_back(beat_row(OP_POLL,  32'd16, 1'b1, 6'b000010)); // clock on the dot
    dir_rows.push_back(beat_row(OP_ALIGN, 32'hFFFF_FFF0, 1'b1, 6'b000000));
    dir_rows.push_back(beat_row(OP_POLL,  32'h0000_0010, 1'b0, '0)); // time wraps
    dir_rows.push_back(beat_row(OP_ALIGN, 32'd0, 1'b1, 6'b000000));
    dir_rows.push_back(beat_row(OP_POLL,  32'h8000_0000, 1'b1, 6'b111111)); // all long overdue
    dir_rows.push_back(beat_row(OP_POLL,  32'h8000_0000, 1'b1, 6'b000000)); // all just resynced
    dir_rows.push_back(beat_row(OP_ALIGN, 32'd1000, 1'b1, 6'b000000));
    dir_rows.push_back(beat_row(OP_POLL,  32'd1020, 1'b0, '0)); // fan at exactly 2x: step
    dir_rows.push_back(beat_row(OP_ALIGN, 32'd1000, 1'b1, 6'b000000));
    dir_rows.push_back(beat_row(OP_POLL,  32'd1021, 1'b0, '0)); // fan past 2x: resync
    dir_rows.push_back(beat_row(OP_POLL,  32'hFFFF_FFFF, 1'b0, '0));
    // Extreme periods, zero included, plus writes to unused indexes.
    dir_rows.push_back(cfg_row(3'd0, 16'd0));
    dir_rows.push_back(cfg_row(3'd1, 16'hFFFF));
    dir_rows.push_back(cfg_row(3'd2, 16'd1));
    dir_rows.push_back(cfg_row(3'd3, 16'd2));
    dir_rows.push_back(cfg_row(3'd4, 16'hFFFE));
    dir_rows.push_back(cfg_row(3'd5, 16'h8000));
    dir_rows.push_back(cfg_row(3'd6, 16'h1234));
    dir_rows.push_back(cfg_row(3'd7, 16'hFFFF));
    dir_rows.push_back(beat_row(OP_ALIGN, 32'd5, 1'b1, 6'b000000));
    dir_rows.push_back(beat_row(OP_POLL,  32'd5, 1'b0, '0));  // zero period, nothing elapsed
    dir_rows.push_back(beat_row(OP_POLL,  32'd6, 1'b0, '0));  // zero period, resync
    dir_rows.push_back(beat_row(OP_POLL,  32'd5 + 32'd65535, 1'b0, '0));
    dir_rows.push_back(beat_row(OP_POLL,  32'd5 + 32'd131071, 1'b0, '0));
    dir_rows.push_back(beat_row(OP_POLL,  32'hFFFF_FFFF, 1'b0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].per);
      else send_beat(dir_rows[i].op, dir_rows[i].now, dir_rows[i].typed, dir_rows[i].mask);
    end

    // Random phases. Each starts idle with new periods, then runs a mostly
    // well-formed time line: forward steps sized to some task's period,
    // steps landing on the period and doubled-period edges, occasional
    // aligns, jumps anywhere, and steps backward.
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (phase)
          0:       p = 16'd1;
          1:       p = 16'hFFFF;
          2:       p = ptds_per_t'($urandom_range(1, 40));
          3:       p = ptds_per_t'($urandom_range(1, 65535));
          4:       p = ($urandom_range(0, 3) == 0) ? 16'd0 : ptds_per_t'($urandom_range(1, 20));
          default: p = ptds_per_t'($urandom_range(1, 200));
        endcase
        write_reg(i[CFG_IDX_W-1:0], p);
      end
      write_reg(3'(NUM_REGS + (phase % 2)), ptds_per_t'($urandom()));

      in_idle_on  = (phase % 3) != 1;
      out_idle_on = (phase % 4) != 2;
      if (phase == 3) hold_req = 1'b1;

      cur = $urandom();
      send_beat(OP_ALIGN, cur, 1'b0, '0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r    = $urandom_range(0, 99);
        t    = $urandom_range(0, TASKS - 1);
        span = 2 * int'(task_period[t]) + 2;
        if (r < 68) begin
          cur = cur + ptds_time_t'($urandom_range(0, span));
          send_beat(OP_POLL, cur, 1'b0, '0);
        end else if (r < 80) begin
          case ($urandom_range(0, 2))
            0:       cur = cur + ptds_time_t'(task_period[t]);
            1:       cur = cur + ptds_time_t'(span - 2);
            default: cur = cur + ptds_time_t'(span - 1);
          endcase
          send_beat(OP_POLL, cur, 1'b0, '0);
        end else if (r < 89) begin
          send_beat(OP_ALIGN, cur, 1'b0, '0);
        end else if (r < 96) begin
          cur = $urandom();
          send_beat($urandom_range(0, 1) ? OP_POLL : OP_ALIGN, cur, 1'b0, '0);
        end else begin
          cur = cur - ptds_time_t'($urandom_range(1, 64));
          send_beat(OP_POLL, cur, 1'b0, '0);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d align and %0d poll beats over %0d period settings;",
             align_beats, poll_beats, PHASES + 1);
    $display("%0d masks checked, %0d task firings, %0d long result stall(s).",
             masks_checked, fired_bits, long_holds);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
